FILE: src/sjisw_pkg.sv
package sjisw_pkg;

    // Command codes carried in the cmd field
    localparam logic CMD_BYTE  = 1'b0;
    localparam logic CMD_BEGIN = 1'b1;

    // Register word index decoded from paddr
    localparam logic REG_COLUMNS = 1'b0;

    localparam logic [6:0] COLUMNS_RESET = 7'd80;
    localparam int         QUEUE_DEPTH   = 4;

    // Half-width kanji range of JIS codes
    localparam logic [15:0] HALF_LO = 16'h2921;
    localparam logic [15:0] HALF_HI = 16'h2B7E;

    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] ROW_OFFSET  = 8'hE0;
    localparam logic [7:0] RIGHT_HALF  = 8'h80;

    typedef struct packed {
        logic        cmd;
        logic [6:0]  start_col;
        logic [4:0]  start_row;
        logic [11:0] logical_attr;
        logic [7:0]  text_byte;
    } t_in;

    typedef struct packed {
        logic [10:0] cell_addr;
        logic [15:0] char_word;
        logic [7:0]  attr_byte;
        logic        last;
    } t_out;

    // One queued job: first cell, optional right half at the next cell
    typedef struct packed {
        logic [10:0] addr;
        logic [15:0] word;
        logic [7:0]  attr;
        logic        pair;
    } t_job;

    typedef struct packed {
        logic push;
        t_job job;
    } t_push;

    function automatic logic is_lead(input logic [7:0] b);
        return (b inside {[8'h81:8'h9F], [8'hE0:8'hFC]});
    endfunction

    function automatic logic [7:0] map_attr(input logic [11:0] la);
        logic [7:0] a;
        a = 8'h01;
        a[5] = la[0];
        a[6] = la[2];
        a[7] = la[1];
        a[4] = la[11];
        a[3] = la[10];
        a[2] = la[9];
        a[1] = la[8];
        return a;
    endfunction

    // Shift-JIS pair to JIS X 0208, zero for an invalid pair
    function automatic logic [15:0] sjis_to_jis(input logic [7:0] hi, input logic [7:0] lo);
        logic [7:0] h;
        logic [7:0] row;
        logic [7:0] col;
        logic [7:0] l;
        h   = (hi >= 8'hE0) ? hi - 8'h40 : hi;
        row = ((h - 8'h81) << 1) + 8'h21;
        l   = lo;
        if (lo >= 8'h9F) begin
            row = row + 8'd1;
            col = lo - 8'h7E;
        end else begin
            if (lo > 8'h7F) begin
                l = lo - 8'd1;
            end
            col = l - 8'h1F;
        end
        if (!is_lead(hi) || lo < 8'h40 || lo == 8'h7F || lo > 8'hFC || row > 8'h7E) begin
            return 16'h0000;
        end
        return {row, col};
    endfunction

endpackage

FILE: src/sjisw_front.sv
module sjisw_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [6:0]        i_columns,
    input  logic              i_accept,
    input  sjisw_pkg::t_in    i_item,
    output sjisw_pkg::t_push  o_push
);

    logic        r_active,    n_active;
    logic [6:0]  r_column,    n_column;
    logic [10:0] r_cell,      n_cell;
    logic [7:0]  r_attr,      n_attr;
    logic        r_lead_pend, n_lead_pend;
    logic [7:0]  r_lead,      n_lead;

    logic [15:0] cp;
    logic [7:0]  first;
    logic [11:0] row_base;
    logic        advance;
    logic [1:0]  step;
    logic [6:0]  next_col;
    sjisw_pkg::t_push push;

    assign cp       = sjisw_pkg::sjis_to_jis(r_lead, i_item.text_byte);
    assign first    = cp[15:8] + sjisw_pkg::ROW_OFFSET;
    assign row_base = {7'd0, i_item.start_row} * {5'd0, i_columns};
    assign next_col = r_column + {5'd0, step};

    // Classify the item and form at most one job
    always_comb begin
        n_active    = r_active;
        n_column    = r_column;
        n_cell      = r_cell;
        n_attr      = r_attr;
        n_lead_pend = r_lead_pend;
        n_lead      = r_lead;
        advance     = 1'b0;
        step        = 2'd1;
        push.push   = 1'b0;
        push.job    = '{addr: r_cell, word: 16'd0, attr: r_attr, pair: 1'b0};
        if (i_accept) begin
            if (i_item.cmd == sjisw_pkg::CMD_BEGIN) begin
                n_attr      = sjisw_pkg::map_attr(i_item.logical_attr);
                n_column    = i_item.start_col;
                n_cell      = 11'(row_base + {5'd0, i_item.start_col});
                n_lead_pend = 1'b0;
                n_lead      = 8'd0;
                n_active    = i_item.start_col < i_columns;
            end else if (r_active) begin
                if (r_lead_pend) begin
                    n_lead_pend = 1'b0;
                    if (i_item.text_byte == 8'd0) begin
                        n_active = 1'b0;
                    end else begin
                        advance   = 1'b1;
                        push.push = 1'b1;
                        if (cp >= sjisw_pkg::HALF_LO && cp <= sjisw_pkg::HALF_HI) begin
                            push.job.word = {cp[7:0], first | sjisw_pkg::RIGHT_HALF};
                        end else if (r_column + 7'd1 == i_columns) begin
                            push.job.word = {8'd0, sjisw_pkg::CHAR_SPACE};
                        end else begin
                            push.job.word = {cp[7:0], first};
                            push.job.pair = 1'b1;
                            step          = 2'd2;
                        end
                    end
                end else if (i_item.text_byte == 8'd0) begin
                    n_active = 1'b0;
                end else if (sjisw_pkg::is_lead(i_item.text_byte)) begin
                    n_lead_pend = 1'b1;
                    n_lead      = i_item.text_byte;
                end else begin
                    advance       = 1'b1;
                    push.push     = 1'b1;
                    push.job.word = {8'd0, i_item.text_byte};
                end
                // Move past the cells written; stop at the right edge
                if (advance) begin
                    n_cell   = r_cell + {9'd0, step};
                    n_column = next_col;
                    n_active = !(next_col >= i_columns || next_col == 7'd0);
                end
            end
        end
    end

    assign o_push = push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_column    <= 7'd0;
            r_cell      <= 11'd0;
            r_attr      <= 8'd1;
            r_lead_pend <= 1'b0;
            r_lead      <= 8'd0;
        end else begin
            r_active    <= n_active;
            r_column    <= n_column;
            r_cell      <= n_cell;
            r_attr      <= n_attr;
            r_lead_pend <= n_lead_pend;
            r_lead      <= n_lead;
        end
    end

endmodule

FILE: src/sjisw_queue.sv
module sjisw_queue #(
    parameter int DEPTH = sjisw_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sjisw_pkg::t_push  i_push,
    input  logic              i_pop,
    output sjisw_pkg::t_job   o_head,
    output logic              o_head_valid,
    output logic              o_full
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    sjisw_pkg::t_job r_mem [DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_count, n_count;

    // Advance pointers and occupancy
    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push.push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
        end
        if (i_push.push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (i_pop && !i_push.push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // Hold job entries
    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_mem[r_wr] <= i_push.job;
        end
    end

    assign o_head       = r_mem[r_rd];
    assign o_head_valid = r_count != '0;
    assign o_full       = r_count == CW'(DEPTH);

endmodule

FILE: src/sjisw_back.sv
module sjisw_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sjisw_pkg::t_job  i_head,
    input  logic             i_head_valid,
    output logic             o_pop,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output sjisw_pkg::t_out  o_out_data
);

    logic            r_valid, n_valid;
    logic            r_beat,  n_beat;
    sjisw_pkg::t_out r_data,  n_data;
    logic            out_free;

    assign out_free = !r_valid || !i_out_stall;

    // A cell a cycle unless stalled; a pair holds the head until its right half
    always_comb begin
        n_valid = r_valid;
        n_beat  = r_beat;
        n_data  = r_data;
        o_pop   = 1'b0;
        if (out_free) begin
            if (r_beat) begin
                n_data.cell_addr = i_head.addr + 11'd1;
                n_data.char_word = i_head.word | {8'd0, sjisw_pkg::RIGHT_HALF};
                n_data.attr_byte = i_head.attr;
                n_data.last      = 1'b1;
                n_valid          = 1'b1;
                n_beat           = 1'b0;
                o_pop            = 1'b1;
            end else if (i_head_valid) begin
                n_data.cell_addr = i_head.addr;
                n_data.char_word = i_head.word;
                n_data.attr_byte = i_head.attr;
                n_data.last      = !i_head.pair;
                n_valid          = 1'b1;
                n_beat           = i_head.pair;
                o_pop            = !i_head.pair;
            end else begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_beat  <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_beat  <= n_beat;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

endmodule

FILE: src/sjis_text_vram_writer.sv
// An item's job goes into the job queue; its cells leave via the output register.
// Throughput: one item a cycle in while the queue has room; one cell a cycle out
// while not stalled, so a full-width kanji takes two cells, everything else one.
// A job queue of QUEUE_DEPTH entries sits between the decoder and the cell writer.
// Reset (synchronous, active low): idle, no pending lead byte, columns = 80.
module sjis_text_vram_writer #(
    parameter int QUEUE_DEPTH = sjisw_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  sjisw_pkg::t_in   i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output sjisw_pkg::t_out  o_out_data,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [6:0]        r_columns;
    logic              in_accept;
    logic              full;
    logic              pop;
    logic              head_valid;
    sjisw_pkg::t_push  push;
    sjisw_pkg::t_job   head;

    // Register port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_columns <= sjisw_pkg::COLUMNS_RESET;
        end else if (psel && penable && pwrite && paddr[2] == sjisw_pkg::REG_COLUMNS) begin
            r_columns <= pwdata[6:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == sjisw_pkg::REG_COLUMNS) ? {25'd0, r_columns} : 32'd0;

    assign o_in_stall = full;
    assign in_accept  = i_in_valid && !full;

    sjisw_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_columns (r_columns),
        .i_accept  (in_accept),
        .i_item    (i_in_data),
        .o_push    (push)
    );

    sjisw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_pop        (pop),
        .o_head       (head),
        .o_head_valid (head_valid),
        .o_full       (full)
    );

    sjisw_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_head_valid (head_valid),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_data   (o_out_data)
    );

endmodule

FILE: src/sjisw_checker.sv
module sjisw_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_out_valid,
    input logic             i_out_stall,
    input sjisw_pkg::t_out  o_out_data
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_data))
        else $error("stalled result changed");

    // Right half follows its left half at once, at the next cell
    a_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_out_data.last |=>
            o_out_valid && o_out_data.last
            && o_out_data.cell_addr == 11'($past(o_out_data.cell_addr) + 11'd1)
            && o_out_data.char_word[7]
            && o_out_data.char_word[15:8] == $past(o_out_data.char_word[15:8]))
        else $error("right half missing or misplaced");

    // Hardware attribute always carries its marker bit
    a_attr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.attr_byte[0])
        else $error("attribute marker bit clear");

endmodule

bind sjis_text_vram_writer sjisw_checker u_sjisw_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
